/* design/bsis_pkg.sv */
// Shared types, sizes and codes for the binary search tree set block.
`default_nettype none

package bsis_pkg;

	// Node store size and derived widths.
	localparam int CAPACITY  = 256;
	localparam int IDX_W     = $clog2(CAPACITY);
	localparam int LINK_W    = IDX_W + 1;
	localparam int KEY_WIDTH = 32;
	localparam int RES_IDX_W = 8;
	localparam int STATUS_W  = 3;

	// A link is empty when it is not below the node count; all ones always is.
	localparam logic [LINK_W-1:0] LINK_NULL = '1;

	// Operation codes.
	localparam logic FUNC_ADD    = 1'b0;
	localparam logic FUNC_SEARCH = 1'b1;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
	localparam logic [STATUS_W-1:0] ST_PRESENT   = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

	// Which link of the parent an append hangs the new node on.
	localparam logic [1:0] SLOT_ROOT    = 2'd0;
	localparam logic [1:0] SLOT_LESS    = 2'd1;
	localparam logic [1:0] SLOT_GREATER = 2'd2;

	// Source of the reported node index.
	localparam logic [1:0] IDX_ZERO  = 2'd0;
	localparam logic [1:0] IDX_CUR   = 2'd1;
	localparam logic [1:0] IDX_COUNT = 2'd2;

	// Request and response payloads.
	typedef struct packed {
		logic                        func;
		logic signed [KEY_WIDTH-1:0] key;
	} bsis_req_t;

	typedef struct packed {
		logic [STATUS_W-1:0]  status;
		logic [RES_IDX_W-1:0] node_index;
	} bsis_rsp_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic                capture;
		logic                step;
		logic                append;
		logic                link;
		logic                res_set;
		logic [STATUS_W-1:0] res_code;
		logic [1:0]          idx_sel;
		logic                out_load;
	} bsis_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic cur_valid;
		logic key_eq;
		logic is_search;
		logic store_full;
	} bsis_sts_t;

endpackage

`default_nettype wire

/* design/bsis_datapath.sv */
// Datapath of the tree set: node store memories, walk registers and result registers.
`default_nettype none

module bsis_datapath (
	input  wire                clk,
	input  wire                arst_n,
	input  bsis_pkg::bsis_req_t req,
	input  bsis_pkg::bsis_cmd_t cmd,
	output bsis_pkg::bsis_sts_t sts,
	output bsis_pkg::bsis_rsp_t rsp
);

	// Node store: one memory per node field.
	logic signed [bsis_pkg::KEY_WIDTH-1:0] key_mem [bsis_pkg::CAPACITY];
	logic [bsis_pkg::LINK_W-1:0]           less_mem [bsis_pkg::CAPACITY];
	logic [bsis_pkg::LINK_W-1:0]           grt_mem [bsis_pkg::CAPACITY];

	logic signed [bsis_pkg::KEY_WIDTH-1:0] key_rd_q;
	logic [bsis_pkg::LINK_W-1:0]           less_rd_q;
	logic [bsis_pkg::LINK_W-1:0]           grt_rd_q;

	// Tree and walk state.
	logic [bsis_pkg::LINK_W-1:0]           root_q;
	logic [bsis_pkg::LINK_W-1:0]           count_q;
	logic [bsis_pkg::LINK_W-1:0]           cur_q;
	logic [bsis_pkg::IDX_W-1:0]            parent_q;
	logic [1:0]                            slot_q;
	logic                                  func_q;
	logic signed [bsis_pkg::KEY_WIDTH-1:0] key_q;
	bsis_pkg::bsis_rsp_t                   res_q;
	bsis_pkg::bsis_rsp_t                   out_q;

	logic                                  key_lt;
	logic [bsis_pkg::LINK_W-1:0]           next_link;
	logic [bsis_pkg::IDX_W-1:0]            rd_addr;
	logic [bsis_pkg::IDX_W-1:0]            new_idx;
	logic                                  less_we;
	logic                                  grt_we;
	logic [bsis_pkg::IDX_W-1:0]            link_wa;
	logic [bsis_pkg::LINK_W-1:0]           link_wd;

	// Compare the search key with the node just read and pick the next link.
	assign key_lt    = key_q < key_rd_q;
	assign next_link = key_lt ? less_rd_q : grt_rd_q;
	assign new_idx   = count_q[bsis_pkg::IDX_W-1:0];

	// Read address: the root on a new transfer, the chosen child while walking.
	always_comb begin
		if (cmd.capture) begin
			rd_addr = root_q[bsis_pkg::IDX_W-1:0];
		end else if (cmd.step) begin
			rd_addr = next_link[bsis_pkg::IDX_W-1:0];
		end else begin
			rd_addr = cur_q[bsis_pkg::IDX_W-1:0];
		end
	end

	// Link memory writes: empty links for a new node, or the parent's link to it.
	assign less_we = cmd.append || (cmd.link && slot_q == bsis_pkg::SLOT_LESS);
	assign grt_we  = cmd.append || (cmd.link && slot_q == bsis_pkg::SLOT_GREATER);
	assign link_wa = cmd.append ? new_idx : parent_q;
	assign link_wd = cmd.append ? bsis_pkg::LINK_NULL : count_q;

	// Key memory.
	always_ff @(posedge clk) begin
		if (cmd.append) begin
			key_mem[new_idx] <= key_q;
		end
		key_rd_q <= key_mem[rd_addr];
	end

	// Less-than link memory.
	always_ff @(posedge clk) begin
		if (less_we) begin
			less_mem[link_wa] <= link_wd;
		end
		less_rd_q <= less_mem[rd_addr];
	end

	// Greater-than link memory.
	always_ff @(posedge clk) begin
		if (grt_we) begin
			grt_mem[link_wa] <= link_wd;
		end
		grt_rd_q <= grt_mem[rd_addr];
	end

	// Root link and node count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_q  <= bsis_pkg::LINK_NULL;
			count_q <= '0;
		end else if (cmd.link) begin
			if (slot_q == bsis_pkg::SLOT_ROOT) begin
				root_q <= count_q;
			end
			count_q <= count_q + 1'b1;
		end
	end

	// Walk registers: loaded on a new transfer, advanced one node per cycle.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q   <= req.func;
			key_q    <= req.key;
			cur_q    <= root_q;
			parent_q <= '0;
			slot_q   <= bsis_pkg::SLOT_ROOT;
		end else if (cmd.step) begin
			cur_q    <= next_link;
			parent_q <= cur_q[bsis_pkg::IDX_W-1:0];
			slot_q   <= key_lt ? bsis_pkg::SLOT_LESS : bsis_pkg::SLOT_GREATER;
		end
	end

	// Result register and output register.
	always_ff @(posedge clk) begin
		if (cmd.res_set) begin
			res_q.status <= cmd.res_code;
			case (cmd.idx_sel)
				bsis_pkg::IDX_CUR: begin
					res_q.node_index <= bsis_pkg::RES_IDX_W'(cur_q);
				end
				bsis_pkg::IDX_COUNT: begin
					res_q.node_index <= bsis_pkg::RES_IDX_W'(count_q);
				end
				default: begin
					res_q.node_index <= '0;
				end
			endcase
		end
		if (cmd.out_load) begin
			out_q <= res_q;
		end
	end

	// Status toward the controller.
	assign sts.cur_valid  = cur_q < count_q;
	assign sts.key_eq     = key_q == key_rd_q;
	assign sts.is_search  = func_q == bsis_pkg::FUNC_SEARCH;
	assign sts.store_full = count_q == bsis_pkg::LINK_W'(bsis_pkg::CAPACITY);

	assign rsp = out_q;

endmodule

`default_nettype wire

/* design/bsis_ctrl.sv */
// Controller state machine of the tree set: sequences walk, append, link and output.
`default_nettype none

module bsis_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 req_valid,
	output logic                req_ready,
	output logic                rsp_valid,
	input  wire                 rsp_ready,
	input  bsis_pkg::bsis_sts_t sts,
	output bsis_pkg::bsis_cmd_t cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_WALK = 2'd1;
	localparam logic [1:0] S_LINK = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_nxt;
	logic       rsp_valid_q;

	assign req_ready = state_q == S_IDLE;
	assign rsp_valid = rsp_valid_q;

	// Next state and commands.
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_nxt   = S_WALK;
				end
			end
			S_WALK: begin
				if (sts.cur_valid && sts.key_eq) begin
					cmd.res_set  = 1'b1;
					cmd.res_code = sts.is_search ? bsis_pkg::ST_FOUND : bsis_pkg::ST_PRESENT;
					cmd.idx_sel  = bsis_pkg::IDX_CUR;
					state_nxt    = S_DONE;
				end else if (sts.cur_valid) begin
					cmd.step = 1'b1;
				end else if (sts.is_search) begin
					cmd.res_set  = 1'b1;
					cmd.res_code = bsis_pkg::ST_NOT_FOUND;
					cmd.idx_sel  = bsis_pkg::IDX_ZERO;
					state_nxt    = S_DONE;
				end else if (sts.store_full) begin
					cmd.res_set  = 1'b1;
					cmd.res_code = bsis_pkg::ST_FULL;
					cmd.idx_sel  = bsis_pkg::IDX_ZERO;
					state_nxt    = S_DONE;
				end else begin
					cmd.append = 1'b1;
					state_nxt  = S_LINK;
				end
			end
			S_LINK: begin
				cmd.link     = 1'b1;
				cmd.res_set  = 1'b1;
				cmd.res_code = bsis_pkg::ST_INSERTED;
				cmd.idx_sel  = bsis_pkg::IDX_COUNT;
				state_nxt    = S_DONE;
			end
			S_DONE: begin
				if (!rsp_valid_q || rsp_ready) begin
					cmd.out_load = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// State register and output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

/* design/bst_set_insert_search.sv */
// Top level of the binary search tree set: add and search of signed keys.
//
//   Channel | Direction | Handshake             | Payload
//   req     | in        | req_valid / req_ready | func, key
//   rsp     | out       | rsp_valid / rsp_ready | status, node_index
//
// The output register is loaded from the result register after the walk ends: on a
// match, on a failed search or a full store, or on an insert, which first writes
// the new node and then links it to its parent. The walk reads one node per cycle
// from the node store memories, and the next request is taken in the cycle after
// the output register is loaded.
// Reset empties the tree at once; the node store needs no clearing pass.
// A new request is taken while an earlier result still waits in the output
// register; a stalled output holds the next result until the register frees.
`default_nettype none

module bst_set_insert_search (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 req_valid,
	output logic                req_ready,
	input  bsis_pkg::bsis_req_t req,
	output logic                rsp_valid,
	input  wire                 rsp_ready,
	output bsis_pkg::bsis_rsp_t rsp
);

	bsis_pkg::bsis_cmd_t cmd;
	bsis_pkg::bsis_sts_t sts;

	// Sequencing.
	bsis_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Node store and walk.
	bsis_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.rsp    (rsp)
	);

endmodule

`default_nettype wire

/* tb/sv/bst_set_insert_search_test.sv */
// Self-checking testbench for the binary search tree set with add and search of signed keys.
`timescale 1ns / 100ps

module bst_set_insert_search_test;
	import bsis_pkg::*;

	localparam int CYCLE_LIMIT = 3000000;
	localparam logic signed [KEY_WIDTH-1:0] KEY_MIN = {1'b1, {(KEY_WIDTH-1){1'b0}}};
	localparam logic signed [KEY_WIDTH-1:0] KEY_MAX = {1'b0, {(KEY_WIDTH-1){1'b1}}};

	logic      clk;
	logic      arst_n = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_ready;
	bsis_req_t req = '0;
	logic      rsp_valid;
	logic      rsp_ready = 1'b0;
	bsis_rsp_t rsp;

	// Shadow copy of the tree, advanced once per accepted request.
	logic signed [KEY_WIDTH-1:0] tree_keys [CAPACITY];
	logic [LINK_W-1:0]           tree_less [CAPACITY];
	logic [LINK_W-1:0]           tree_greater [CAPACITY];
	logic [LINK_W-1:0]           tree_root = LINK_NULL;
	logic [LINK_W-1:0]           tree_size = '0;

	bsis_rsp_t answers_due [$];
	int        fail_count = 0;
	int        cycle_count = 0;
	bit        send_calm = 1'b0;
	bit        recv_calm = 1'b0;
	int        recv_stall = 0;

	bst_set_insert_search DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	// Free-running clock with a 4 ns period.
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Hard stop in case the block hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("bst_set_insert_search_test: FAIL");
			$finish;
		end
	end

	// Walks the shadow tree for one request, applies an insert and returns the answer.
	function automatic bsis_rsp_t bst_answer(input bsis_req_t item);
		bsis_rsp_t         ans;
		logic [LINK_W-1:0] cur;
		logic [IDX_W-1:0]  parent;
		logic [1:0]        slot;
		logic [IDX_W-1:0]  fresh;
		bit                hit;
		int                steps;
		cur = tree_root;
		parent = '0;
		slot = SLOT_ROOT;
		hit = 1'b0;
		steps = 0;
		while (!hit && cur < tree_size && steps <= int'(tree_size)) begin
			if (tree_keys[cur[IDX_W-1:0]] == item.key) begin
				hit = 1'b1;
			end else begin
				parent = cur[IDX_W-1:0];
				if (item.key < tree_keys[cur[IDX_W-1:0]]) begin
					slot = SLOT_LESS;
					cur = tree_less[cur[IDX_W-1:0]];
				end else begin
					slot = SLOT_GREATER;
					cur = tree_greater[cur[IDX_W-1:0]];
				end
				steps++;
			end
		end
		ans.node_index = hit ? RES_IDX_W'(cur) : '0;
		if (item.func == FUNC_SEARCH) begin
			ans.status = hit ? ST_FOUND : ST_NOT_FOUND;
		end else if (hit) begin
			ans.status = ST_PRESENT;
		end else if (tree_size >= CAPACITY) begin
			ans.status = ST_FULL;
		end else begin
			// Append the key as a new leaf and hang it on the link where the walk ended.
			fresh = tree_size[IDX_W-1:0];
			tree_keys[fresh] = item.key;
			tree_less[fresh] = LINK_NULL;
			tree_greater[fresh] = LINK_NULL;
			case (slot)
				SLOT_ROOT: tree_root = tree_size;
				SLOT_LESS: tree_less[parent] = tree_size;
				default: tree_greater[parent] = tree_size;
			endcase
			ans.status = ST_INSERTED;
			ans.node_index = RES_IDX_W'(tree_size);
			tree_size = tree_size + 1'b1;
		end
		return ans;
	endfunction

	// Mostly back to back, sometimes a short gap, now and then a long one.
	function automatic int pick_gap(input bit calm);
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// A key not taken from the tree: extremes, a dense small range, or any value.
	function automatic logic signed [KEY_WIDTH-1:0] fresh_key();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) begin
			case ($urandom_range(0, 3))
				0: return KEY_MIN;
				1: return KEY_MAX;
				2: return '0;
				default: return '1;
			endcase
		end
		if (r < 3)
			return $signed($urandom_range(0, 64)) - 32;
		return $urandom;
	endfunction

	// A key already held by the tree, or a fresh one when the tree is empty.
	function automatic logic signed [KEY_WIDTH-1:0] held_key();
		if (tree_size == 0)
			return fresh_key();
		return tree_keys[$urandom_range(0, int'(tree_size) - 1)];
	endfunction

	// Offers one request and records its answer once the transfer happens.
	task automatic send_item(input logic func, input logic signed [KEY_WIDTH-1:0] key);
		bsis_req_t item;
		int        gap;
		item.func = func;
		item.key = key;
		req <= item;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		answers_due.push_back(bst_answer(item));
		if ($urandom_range(0, 49) == 0)
			send_calm = !send_calm;
		gap = pick_gap(send_calm);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Holds the request side until every answer has come back.
	task automatic wait_drained();
		req_valid <= 1'b0;
		while (answers_due.size() != 0)
			@(posedge clk);
	endtask

	// Empty tree, both extremes, the keys around zero, repeats and misses.
	task automatic test_extremes();
		send_item(FUNC_SEARCH, '0);
		send_item(FUNC_ADD, '0);
		send_item(FUNC_ADD, KEY_MIN);
		send_item(FUNC_ADD, KEY_MAX);
		send_item(FUNC_ADD, '1);
		send_item(FUNC_ADD, 1);
		send_item(FUNC_ADD, '0);
		send_item(FUNC_SEARCH, KEY_MIN);
		send_item(FUNC_SEARCH, KEY_MAX);
		send_item(FUNC_SEARCH, '1);
		send_item(FUNC_SEARCH, KEY_MIN + 1);
		send_item(FUNC_SEARCH, KEY_MAX - 1);
		send_item(FUNC_ADD, KEY_MIN);
	endtask

	// Sorted inserts build one-sided chains, the worst shape for the walk.
	task automatic test_sorted_chain();
		for (int i = 0; i < 6; i++)
			send_item(FUNC_ADD, 1000 + i);
		send_item(FUNC_SEARCH, 1005);
		send_item(FUNC_SEARCH, 1006);
		for (int i = 0; i < 3; i++)
			send_item(FUNC_ADD, -1000 - i);
		send_item(FUNC_SEARCH, -1002);
	endtask

	// Random adds and searches over held and fresh keys, with a full drain halfway.
	task automatic test_random_mix();
		logic signed [KEY_WIDTH-1:0] base;
		for (int i = 0; i < 1000; i++) begin
			if (i == 500)
				wait_drained();
			if ($urandom_range(0, 99) < 3) begin
				// A short sorted run deepens one branch, then its top is looked up.
				base = $urandom;
				for (int j = 0; j < 6; j++)
					send_item(FUNC_ADD, base + j);
				send_item(FUNC_SEARCH, base + 5);
			end else begin
				send_item(logic'($urandom_range(0, 1)),
					($urandom_range(0, 99) < 55) ? held_key() : fresh_key());
			end
		end
	endtask

	// Fill the store, then keep adding and searching against the full tree.
	task automatic test_full_store();
		while (tree_size < CAPACITY)
			send_item(FUNC_ADD, fresh_key());
		send_item(FUNC_ADD, fresh_key());
		send_item(FUNC_ADD, held_key());
		for (int i = 0; i < 600; i++)
			send_item(logic'($urandom_range(0, 1)),
				($urandom_range(0, 1) == 1) ? held_key() : fresh_key());
	endtask

	// Result side: random stalls on ready and a check of every transfer.
	always @(posedge clk) begin
		bsis_rsp_t want;
		logic      ready_next;
		if (arst_n) begin
			ready_next = rsp_ready;
			if (rsp_valid && rsp_ready) begin
				if (answers_due.size() == 0) begin
					$display("%0t: unexpected result, status %0d, node_index %0d",
						$time, rsp.status, rsp.node_index);
					fail_count++;
				end else begin
					want = answers_due.pop_front();
					if (rsp.status !== want.status) begin
						$display("%0t: status mismatch, expected %0d, got %0d",
							$time, want.status, rsp.status);
						fail_count++;
					end
					if (rsp.node_index !== want.node_index) begin
						$display("%0t: node_index mismatch, expected %0d, got %0d",
							$time, want.node_index, rsp.node_index);
						fail_count++;
					end
				end
				if ($urandom_range(0, 49) == 0)
					recv_calm = !recv_calm;
				recv_stall = pick_gap(recv_calm);
			end else if (!recv_calm && recv_stall == 0 && $urandom_range(0, 15) == 0) begin
				recv_stall = $urandom_range(1, 6);
			end
			if (recv_stall > 0) begin
				recv_stall--;
				ready_next = 1'b0;
			end else begin
				ready_next = 1'b1;
			end
			rsp_ready <= ready_next;
		end
	end

	// Reset once, run the tests in turn, then drain and report.
	initial begin
		for (int i = 0; i < CAPACITY; i++) begin
			tree_keys[i] = '0;
			tree_less[i] = LINK_NULL;
			tree_greater[i] = LINK_NULL;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_sorted_chain();
		test_random_mix();
		test_full_store();
		wait_drained();
		repeat (300) @(posedge clk);
		if (fail_count == 0 && answers_due.size() == 0) begin
			$display("bst_set_insert_search_test: PASS");
		end else begin
			$display("bst_set_insert_search_test: FAIL");
		end
		$finish;
	end

endmodule

/* filelist.f */
design/bsis_pkg.sv
design/bsis_datapath.sv
design/bsis_ctrl.sv
design/bst_set_insert_search.sv
tb/sv/bst_set_insert_search_test.sv
